@@ src/atapio_pkg.sv @@
// Shared types and constants for the ATA PIO command sequencer.
package atapio_pkg;

    localparam logic [2:0] MODE_START_READ  = 3'd0;
    localparam logic [2:0] MODE_START_WRITE = 3'd1;
    localparam logic [2:0] MODE_INIT        = 3'd2;
    localparam logic [2:0] MODE_REPLY       = 3'd3;
    localparam logic [2:0] MODE_HOST_WORD   = 3'd4;

    localparam logic [2:0] KIND_BYTE_RD  = 3'd0;
    localparam logic [2:0] KIND_BYTE_WR  = 3'd1;
    localparam logic [2:0] KIND_WORD_RD  = 3'd2;
    localparam logic [2:0] KIND_WORD_WR  = 3'd3;
    localparam logic [2:0] KIND_TO_HOST  = 3'd4;
    localparam logic [2:0] KIND_REQ_HOST = 3'd5;
    localparam logic [2:0] KIND_FINISHED = 3'd6;

    localparam logic [1:0] OUT_OK      = 2'd0;
    localparam logic [1:0] OUT_BAD_CNT = 2'd1;
    localparam logic [1:0] OUT_TIMEOUT = 2'd2;
    localparam logic [1:0] OUT_DEV_ERR = 2'd3;

    localparam logic [2:0] REG_DATA   = 3'd0;
    localparam logic [2:0] REG_COUNT  = 3'd2;
    localparam logic [2:0] REG_LBA0   = 3'd3;
    localparam logic [2:0] REG_LBA1   = 3'd4;
    localparam logic [2:0] REG_LBA2   = 3'd5;
    localparam logic [2:0] REG_DRVHD  = 3'd6;
    localparam logic [2:0] REG_STATUS = 3'd7;

    localparam logic [7:0] DRVHD_BASE = 8'hE0;
    localparam logic [7:0] CMD_READ   = 8'h20;
    localparam logic [7:0] CMD_WRITE  = 8'h30;
    localparam logic [7:0] CMD_FLUSH  = 8'hE7;
    localparam int ST_BSY = 7;
    localparam int ST_RDY = 6;
    localparam int ST_DRQ = 3;
    localparam int ST_ERR = 0;

    localparam logic [23:0] POLL_LIMIT_RESET = 24'd1000000;
    localparam int MAX_BURST = 7;
    localparam int CNT_W = 3;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_NB_READY  = 4'd1;
    localparam logic [3:0] PH_READY     = 4'd2;
    localparam logic [3:0] PH_DELAY_SEL = 4'd3;
    localparam logic [3:0] PH_NB_DRQ    = 4'd4;
    localparam logic [3:0] PH_DRQ       = 4'd5;
    localparam logic [3:0] PH_RD_WORD   = 4'd6;
    localparam logic [3:0] PH_WR_HOST   = 4'd7;
    localparam logic [3:0] PH_DELAY_SEC = 4'd8;
    localparam logic [3:0] PH_FLUSH_NB  = 4'd9;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  reg_offset;
        logic [15:0] value;
        logic [1:0]  outcome;
    } result_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [27:0] block_address;
        logic [8:0]  sector_total;
        logic [15:0] data_word;
    } item_t;

    typedef struct packed {
        result_t [MAX_BURST-1:0] res;
        logic [CNT_W-1:0]        count;
    } burst_t;

endpackage

@@ src/ata_pio_command_sequencer.sv @@
// Top level of the ATA PIO LBA28 polled host sequencer.
// Usage: start items (mode 0 read, 1 write, 2 init) and bus replies / host
// words (modes 3, 4) arrive on the s_ channel. Each item is registered, then
// the state logic turns it into a burst of 0 to 6 result beats held
// in a burst buffer; beats leave on the m_ channel, m_last on the final one.
// The first beat follows the item register, then the burst buffer load.
// Throughput: one item per cycle while each item yields at most one beat
// and m_ready is high; a multi-beat item holds the m_ side until its beats
// leave the single read port of the burst buffer. No-beat items leave it empty.
// Reset clears the sequencer to idle and poll_limit to 1000000.
// When m_ready is low the buffer holds, the item register fills, and
// s_ready drops until the burst drains.
// cfg_* writes poll_limit and is always ready.
module ata_pio_command_sequencer #(
    parameter int WORDS_PER_SECTOR = 256,
    parameter int MAX_SECTORS      = 256,
    parameter int DELAY_READS      = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [27:0] s_block_address,
    input  logic [8:0]  s_sector_total,
    input  logic [15:0] s_data_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [2:0]  m_reg_offset,
    output logic [15:0] m_value,
    output logic [1:0]  m_outcome,
    output logic        m_last
);

    logic [23:0] limit_reg;
    atapio_pkg::item_t item_reg;
    logic        item_vld_reg;
    logic        can_load, step_en;
    atapio_pkg::burst_t burst;

    assign cfg_ready = 1'b1;
    assign step_en = item_vld_reg && can_load;
    assign s_ready = !item_vld_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) limit_reg <= atapio_pkg::POLL_LIMIT_RESET;
        else if (cfg_valid) limit_reg <= cfg_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) item_vld_reg <= 1'b0;
        else if (s_ready) item_vld_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg.mode <= s_mode;
            item_reg.block_address <= s_block_address;
            item_reg.sector_total <= s_sector_total;
            item_reg.data_word <= s_data_word;
        end
    end

    atapio_step #(
        .WORDS_PER_SECTOR(WORDS_PER_SECTOR),
        .MAX_SECTORS(MAX_SECTORS),
        .DELAY_READS(DELAY_READS)
    ) u_step (
        .aclk(aclk), .aresetn(aresetn), .step_en(step_en),
        .item(item_reg), .poll_limit(limit_reg), .burst(burst)
    );

    // zero-beat bursts still load: count 0 leaves the buffer empty
    atapio_out u_out (
        .aclk(aclk), .aresetn(aresetn), .load(step_en), .burst(burst),
        .can_load(can_load), .m_valid(m_valid), .m_ready(m_ready),
        .m_kind(m_kind), .m_reg_offset(m_reg_offset), .m_value(m_value),
        .m_outcome(m_outcome), .m_last(m_last)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        item_vld_reg && !can_load |-> !s_ready)
        else $error("input taken while item register blocked");

endmodule

@@ src/atapio_step.sv @@
// Sequencer state and per-item result burst generation.
module atapio_step #(
    parameter int WORDS_PER_SECTOR = 256,
    parameter int MAX_SECTORS      = 256,
    parameter int DELAY_READS      = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  atapio_pkg::item_t    item,
    input  logic [23:0]          poll_limit,
    output atapio_pkg::burst_t   burst
);

    logic [3:0]  phase_reg, phase_next;
    logic [23:0] poll_reg, poll_next;
    logic [8:0]  sleft_reg, sleft_next;
    logic [7:0]  widx_reg, widx_next;
    logic [1:0]  didx_reg, didx_next;
    logic [27:0] addr_reg, addr_next;
    logic [8:0]  total_reg, total_next;
    logic        wr_reg, wr_next;

    logic [7:0] st;
    atapio_pkg::burst_t b;

    assign st = item.data_word[7:0];
    assign burst = b;

    function automatic atapio_pkg::result_t mk(logic [2:0] k, logic [2:0] o,
                                               logic [15:0] v, logic [1:0] oc);
        atapio_pkg::result_t r;
        r.kind = k; r.reg_offset = o; r.value = v; r.outcome = oc;
        return r;
    endfunction

    always_comb begin
        atapio_pkg::result_t rd7;
        rd7 = mk(atapio_pkg::KIND_BYTE_RD, atapio_pkg::REG_STATUS, 16'd0,
                 atapio_pkg::OUT_OK);
        phase_next = phase_reg; poll_next = poll_reg; sleft_next = sleft_reg;
        widx_next = widx_reg; didx_next = didx_reg; addr_next = addr_reg;
        total_next = total_reg; wr_next = wr_reg;
        b = '0;
        if (phase_reg == atapio_pkg::PH_IDLE) begin
            if (item.mode == atapio_pkg::MODE_START_READ ||
                item.mode == atapio_pkg::MODE_START_WRITE) begin
                if (item.sector_total == 9'd0 ||
                    32'(item.sector_total) > 32'(MAX_SECTORS)) begin
                    b.res[0] = mk(atapio_pkg::KIND_FINISHED, 3'd0, 16'd0,
                                  atapio_pkg::OUT_BAD_CNT);
                    b.count = 3'd1;
                end else begin
                    addr_next = item.block_address;
                    total_next = item.sector_total;
                    sleft_next = item.sector_total;
                    wr_next = item.mode[0];
                    poll_next = poll_limit;
                    phase_next = atapio_pkg::PH_NB_READY;
                    b.res[0] = rd7; b.count = 3'd1;
                end
            end else if (item.mode == atapio_pkg::MODE_INIT) begin
                total_next = 9'd0; wr_next = 1'b0; didx_next = 2'd0;
                phase_next = atapio_pkg::PH_DELAY_SEL;
                b.res[0] = mk(atapio_pkg::KIND_BYTE_WR, atapio_pkg::REG_DRVHD,
                              {8'd0, atapio_pkg::DRVHD_BASE}, atapio_pkg::OUT_OK);
                b.res[1] = rd7; b.count = 3'd2;
            end
        end else if (phase_reg == atapio_pkg::PH_WR_HOST ||
                     phase_reg == atapio_pkg::PH_RD_WORD) begin
            if ((phase_reg == atapio_pkg::PH_WR_HOST &&
                 item.mode == atapio_pkg::MODE_HOST_WORD) ||
                (phase_reg == atapio_pkg::PH_RD_WORD &&
                 item.mode == atapio_pkg::MODE_REPLY)) begin
                b.res[0] = mk(wr_reg ? atapio_pkg::KIND_WORD_WR
                                     : atapio_pkg::KIND_TO_HOST,
                              3'd0, item.data_word, atapio_pkg::OUT_OK);
                b.count = 3'd2;
                if (32'(widx_reg) == WORDS_PER_SECTOR - 1) begin
                    didx_next = 2'd0;
                    phase_next = atapio_pkg::PH_DELAY_SEC;
                    b.res[1] = rd7;
                end else begin
                    widx_next = widx_reg + 8'd1;
                    b.res[1] = mk(wr_reg ? atapio_pkg::KIND_REQ_HOST
                                         : atapio_pkg::KIND_WORD_RD,
                                  3'd0, 16'd0, atapio_pkg::OUT_OK);
                end
            end
        end else if (item.mode == atapio_pkg::MODE_REPLY) begin
            b.count = 3'd1;
            // default for failed polls: re-poll or time out (flush polling finishes OK)
            if (poll_reg <= 24'd1) begin
                phase_next = atapio_pkg::PH_IDLE;
                b.res[0] = mk(atapio_pkg::KIND_FINISHED, 3'd0, 16'd0,
                              phase_reg == atapio_pkg::PH_FLUSH_NB ?
                              atapio_pkg::OUT_OK : atapio_pkg::OUT_TIMEOUT);
            end else begin
                poll_next = poll_reg - 24'd1;
                b.res[0] = rd7;
            end
            case (phase_reg)
                atapio_pkg::PH_NB_READY, atapio_pkg::PH_NB_DRQ: begin
                    if (!st[atapio_pkg::ST_BSY]) begin
                        poll_next = poll_limit;
                        phase_next = (phase_reg == atapio_pkg::PH_NB_READY) ?
                                     atapio_pkg::PH_READY : atapio_pkg::PH_DRQ;
                        b.res[0] = rd7;
                    end
                end
                atapio_pkg::PH_READY: begin
                    if (st[atapio_pkg::ST_RDY]) begin
                        if (total_reg == 9'd0) begin
                            phase_next = atapio_pkg::PH_IDLE;
                            b.res[0] = mk(atapio_pkg::KIND_FINISHED, 3'd0, 16'd0,
                                          atapio_pkg::OUT_OK);
                            poll_next = poll_reg;
                        end else begin
                            didx_next = 2'd0;
                            phase_next = atapio_pkg::PH_DELAY_SEL;
                            b.res[0] = mk(atapio_pkg::KIND_BYTE_WR,
                                atapio_pkg::REG_DRVHD,
                                {8'd0, atapio_pkg::DRVHD_BASE | {4'd0, addr_reg[27:24]}},
                                atapio_pkg::OUT_OK);
                            b.res[1] = rd7; b.count = 3'd2;
                            poll_next = poll_reg;
                        end
                    end
                end
                atapio_pkg::PH_DELAY_SEL: begin
                    poll_next = poll_reg;
                    phase_next = phase_reg;
                    if (32'(didx_reg) == DELAY_READS - 1) begin
                        poll_next = poll_limit;
                        if (total_reg == 9'd0) begin
                            phase_next = atapio_pkg::PH_NB_READY;
                            b.res[0] = rd7;
                        end else begin
                            phase_next = atapio_pkg::PH_NB_DRQ;
                            b.res[0] = mk(atapio_pkg::KIND_BYTE_WR, atapio_pkg::REG_COUNT,
                                          {8'd0, total_reg[7:0]}, atapio_pkg::OUT_OK);
                            b.res[1] = mk(atapio_pkg::KIND_BYTE_WR, atapio_pkg::REG_LBA0,
                                          {8'd0, addr_reg[7:0]}, atapio_pkg::OUT_OK);
                            b.res[2] = mk(atapio_pkg::KIND_BYTE_WR, atapio_pkg::REG_LBA1,
                                          {8'd0, addr_reg[15:8]}, atapio_pkg::OUT_OK);
                            b.res[3] = mk(atapio_pkg::KIND_BYTE_WR, atapio_pkg::REG_LBA2,
                                          {8'd0, addr_reg[23:16]}, atapio_pkg::OUT_OK);
                            b.res[4] = mk(atapio_pkg::KIND_BYTE_WR, atapio_pkg::REG_STATUS,
                                          {8'd0, wr_reg ? atapio_pkg::CMD_WRITE
                                                        : atapio_pkg::CMD_READ},
                                          atapio_pkg::OUT_OK);
                            b.res[5] = rd7;
                            b.count = 3'd6;
                        end
                    end else begin
                        didx_next = didx_reg + 2'd1;
                        b.res[0] = rd7;
                    end
                end
                atapio_pkg::PH_DRQ: begin
                    if (st[atapio_pkg::ST_DRQ]) begin
                        poll_next = poll_reg;
                        widx_next = 8'd0;
                        phase_next = wr_reg ? atapio_pkg::PH_WR_HOST
                                            : atapio_pkg::PH_RD_WORD;
                        b.res[0] = mk(wr_reg ? atapio_pkg::KIND_REQ_HOST
                                             : atapio_pkg::KIND_WORD_RD,
                                      3'd0, 16'd0, atapio_pkg::OUT_OK);
                    end else if (st[atapio_pkg::ST_ERR]) begin
                        poll_next = poll_reg;
                        phase_next = atapio_pkg::PH_IDLE;
                        b.res[0] = mk(atapio_pkg::KIND_FINISHED, 3'd0, 16'd0,
                                      atapio_pkg::OUT_DEV_ERR);
                    end
                end
                atapio_pkg::PH_DELAY_SEC: begin
                    poll_next = poll_reg;
                    phase_next = phase_reg;
                    if (32'(didx_reg) == DELAY_READS - 1) begin
                        sleft_next = sleft_reg - 9'd1;
                        if (sleft_reg == 9'd1) begin
                            if (wr_reg) begin
                                poll_next = poll_limit;
                                phase_next = atapio_pkg::PH_FLUSH_NB;
                                b.res[0] = mk(atapio_pkg::KIND_BYTE_WR,
                                    atapio_pkg::REG_STATUS,
                                    {8'd0, atapio_pkg::CMD_FLUSH}, atapio_pkg::OUT_OK);
                                b.res[1] = rd7; b.count = 3'd2;
                            end else begin
                                phase_next = atapio_pkg::PH_IDLE;
                                b.res[0] = mk(atapio_pkg::KIND_FINISHED, 3'd0,
                                              16'd0, atapio_pkg::OUT_OK);
                            end
                        end else begin
                            poll_next = poll_limit;
                            phase_next = atapio_pkg::PH_NB_DRQ;
                            b.res[0] = rd7;
                        end
                    end else begin
                        didx_next = didx_reg + 2'd1;
                        b.res[0] = rd7;
                    end
                end
                atapio_pkg::PH_FLUSH_NB: begin
                    if (!st[atapio_pkg::ST_BSY]) begin
                        poll_next = poll_reg;
                        phase_next = atapio_pkg::PH_IDLE;
                        b.res[0] = mk(atapio_pkg::KIND_FINISHED, 3'd0, 16'd0,
                                      atapio_pkg::OUT_OK);
                    end
                end
                default: begin
                    poll_next = poll_reg;
                    phase_next = atapio_pkg::PH_IDLE;
                    b.count = 3'd0;
                    b.res[0] = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= atapio_pkg::PH_IDLE;
            poll_reg <= '0; sleft_reg <= '0; widx_reg <= '0; didx_reg <= '0;
            addr_reg <= '0; total_reg <= '0; wr_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next; poll_reg <= poll_next;
            sleft_reg <= sleft_next; widx_reg <= widx_next;
            didx_reg <= didx_next; addr_reg <= addr_next;
            total_reg <= total_next; wr_reg <= wr_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && b.count != 3'd0 && b.res[0].kind == atapio_pkg::KIND_FINISHED
        |=> phase_reg == atapio_pkg::PH_IDLE)
        else $error("finish without returning to idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        b.count <= 3'(atapio_pkg::MAX_BURST))
        else $error("burst too long");
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != atapio_pkg::PH_IDLE && phase_reg != atapio_pkg::PH_DELAY_SEL
        |-> total_reg != 9'd0 || phase_reg == atapio_pkg::PH_NB_READY
            || phase_reg == atapio_pkg::PH_READY)
        else $error("init sequence in transfer phase");

endmodule

@@ src/atapio_out.sv @@
// Result burst buffer: holds one burst and streams its beats out.
module atapio_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  atapio_pkg::burst_t  burst,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_kind,
    output logic [2:0]          m_reg_offset,
    output logic [15:0]         m_value,
    output logic [1:0]          m_outcome,
    output logic                m_last
);

    atapio_pkg::result_t [atapio_pkg::MAX_BURST-1:0] buf_reg;
    logic [2:0] cnt_reg, pos_reg;
    logic       pop;

    assign m_valid = cnt_reg != 3'd0;
    assign pop = m_valid && m_ready;
    // accept a new burst when empty or once the final beat of the current one leaves
    assign can_load = !m_valid || (pop && pos_reg == cnt_reg - 3'd1);
    assign m_kind = buf_reg[pos_reg].kind;
    assign m_reg_offset = buf_reg[pos_reg].reg_offset;
    assign m_value = buf_reg[pos_reg].value;
    assign m_outcome = buf_reg[pos_reg].outcome;
    assign m_last = pos_reg == cnt_reg - 3'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            pos_reg <= '0;
        end else if (load && can_load) begin
            cnt_reg <= burst.count;
            pos_reg <= '0;
        end else if (pop) begin
            if (m_last) cnt_reg <= '0;
            pos_reg <= m_last ? 3'd0 : pos_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && can_load) buf_reg <= burst.res;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pos_reg < cnt_reg)
        else $error("read position past burst end");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(pos_reg))
        else $error("stalled beat moved");

endmodule
